// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent holds -> consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/pszbe_pkg.sv
// ----------------------------------------------------------------------------
// pszbe_pkg
// Shared types and constants of the parking sensor zone and beep encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pszbe_pkg;

	localparam int DIST_W  = 8;
	localparam int ZONE_W  = 4;
	localparam int CHAN_W  = 2;
	localparam int DELAY_W = 6;
	localparam int IDX_W   = 4;

	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [ZONE_W-1:0]  zone_t;
	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [DELAY_W-1:0] delay_t;
	typedef logic [IDX_W-1:0]   cfg_idx_t;
	typedef logic [3:0][DIST_W-1:0] limits_t;

	// register indexes
	localparam cfg_idx_t REG_CENTRE_ONE   = 4'd0;
	localparam cfg_idx_t REG_CENTRE_TWO   = 4'd1;
	localparam cfg_idx_t REG_CENTRE_THREE = 4'd2;
	localparam cfg_idx_t REG_CENTRE_FOUR  = 4'd3;
	localparam cfg_idx_t REG_CORNER_ONE   = 4'd4;
	localparam cfg_idx_t REG_CORNER_TWO   = 4'd5;
	localparam cfg_idx_t REG_CORNER_THREE = 4'd6;
	localparam cfg_idx_t REG_CORNER_FOUR  = 4'd7;

	// reset thresholds
	localparam dist_t RST_CENTRE_ONE   = 8'd145;
	localparam dist_t RST_CENTRE_TWO   = 8'd100;
	localparam dist_t RST_CENTRE_THREE = 8'd50;
	localparam dist_t RST_CENTRE_FOUR  = 8'd30;
	localparam dist_t RST_CORNER_ONE   = 8'd60;
	localparam dist_t RST_CORNER_TWO   = 8'd45;
	localparam dist_t RST_CORNER_THREE = 8'd30;
	localparam dist_t RST_CORNER_FOUR  = 8'd20;

	localparam dist_t NOTHING_SEEN = 8'hFF;

	// beep channel codes
	localparam chan_t CHAN_BOTH  = 2'd0;
	localparam chan_t CHAN_LEFT  = 2'd1;
	localparam chan_t CHAN_RIGHT = 2'd2;

	// beep delays
	localparam delay_t DELAY_SLOWEST   = 6'd62;
	localparam delay_t DELAY_TWO_BAR   = 6'd40;
	localparam delay_t DELAY_THREE_BAR = 6'd20;
	localparam delay_t DELAY_CONT      = 6'd0;

	// zones
	localparam zone_t ZONE_1   = 4'd1;
	localparam zone_t ZONE_2   = 4'd2;
	localparam zone_t ZONE_3   = 4'd3;
	localparam zone_t ZONE_4   = 4'd4;
	localparam zone_t ZONE_5   = 4'd5;
	localparam zone_t ZONE_7   = 4'd7;
	localparam zone_t ZONE_FAR = 4'd8;

endpackage

// File: rtl/core/parking_sensor_zone_beep_encoder.sv
// ----------------------------------------------------------------------------
// parking_sensor_zone_beep_encoder
// Turns one frame of four rear distances into zones, beep channel and delay.
// ----------------------------------------------------------------------------
// Takes one sensor frame per clock while out_ready stays high and has no state
// between frames. A frame goes through an input register and a result register
// with the decode logic between them, and the block accepts a new beat every
// cycle while out_ready stays high. The eight thresholds are written through
// cfg_write/cfg_index/cfg_data and should only change while no frame is in
// flight; indexes above 7 are ignored.
`timescale 1ns / 1ps

module parking_sensor_zone_beep_encoder (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_write,
	input  pszbe_pkg::cfg_idx_t     cfg_index,
	input  pszbe_pkg::dist_t        cfg_data,

	input  logic                    in_valid,
	output logic                    in_ready,
	input  pszbe_pkg::dist_t        left_corner_dist,
	input  pszbe_pkg::dist_t        right_corner_dist,
	input  pszbe_pkg::dist_t        left_centre_dist,
	input  pszbe_pkg::dist_t        right_centre_dist,
	input  logic                    reverse_engaged,
	input  logic                    sound_allowed,
	input  logic                    radar_valid,

	output logic                    out_valid,
	input  logic                    out_ready,
	output pszbe_pkg::dist_t        nearest_dist,
	output logic                    nearest_is_corner,
	output pszbe_pkg::zone_t        centre_zone,
	output pszbe_pkg::zone_t        left_zone,
	output pszbe_pkg::zone_t        right_zone,
	output pszbe_pkg::chan_t        beep_channel,
	output pszbe_pkg::delay_t       beep_pause,
	output logic                    rear_active,
	output logic                    sound_on,
	output logic                    show_display
);

	function automatic pszbe_pkg::zone_t centre_zone_of(pszbe_pkg::dist_t d,
			pszbe_pkg::limits_t lim);
		pszbe_pkg::zone_t z;
		z = pszbe_pkg::ZONE_FAR;
		if (d <= lim[0]) z = pszbe_pkg::ZONE_7;
		if (d <= lim[1]) z = pszbe_pkg::ZONE_5;
		if (d <= lim[2]) z = pszbe_pkg::ZONE_3;
		if (d <= lim[3]) z = pszbe_pkg::ZONE_1;
		return z;
	endfunction

	function automatic pszbe_pkg::zone_t corner_zone_of(pszbe_pkg::dist_t d,
			pszbe_pkg::limits_t lim);
		pszbe_pkg::zone_t z;
		z = pszbe_pkg::ZONE_FAR;
		if (d <= lim[0]) z = pszbe_pkg::ZONE_4;
		if (d <= lim[1]) z = pszbe_pkg::ZONE_3;
		if (d <= lim[2]) z = pszbe_pkg::ZONE_2;
		if (d <= lim[3]) z = pszbe_pkg::ZONE_1;
		return z;
	endfunction

	// base - ceil(2*diff/5), clamped at zero; /5 via *205 >> 10 (exact below 1024)
	function automatic pszbe_pkg::delay_t fifth_step(pszbe_pkg::delay_t base,
			pszbe_pkg::dist_t diff);
		logic [9:0]  x;
		logic [17:0] prod;
		logic [7:0]  step;
		x    = {1'b0, diff, 1'b0} + 10'd4;
		prod = {8'd0, x} * 18'd205;
		step = prod[17:10];
		return (step >= {2'b00, base}) ? pszbe_pkg::DELAY_CONT
			: 6'({2'b00, base} - step);
	endfunction

	// ---------------------------------------------------------------- config
	pszbe_pkg::limits_t centre_lim_q;
	pszbe_pkg::limits_t corner_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_lim_q <= {pszbe_pkg::RST_CENTRE_FOUR, pszbe_pkg::RST_CENTRE_THREE,
				pszbe_pkg::RST_CENTRE_TWO, pszbe_pkg::RST_CENTRE_ONE};
			corner_lim_q <= {pszbe_pkg::RST_CORNER_FOUR, pszbe_pkg::RST_CORNER_THREE,
				pszbe_pkg::RST_CORNER_TWO, pszbe_pkg::RST_CORNER_ONE};
		end else if (cfg_write) begin
			unique case (cfg_index)
				pszbe_pkg::REG_CENTRE_ONE:   centre_lim_q[0] <= cfg_data;
				pszbe_pkg::REG_CENTRE_TWO:   centre_lim_q[1] <= cfg_data;
				pszbe_pkg::REG_CENTRE_THREE: centre_lim_q[2] <= cfg_data;
				pszbe_pkg::REG_CENTRE_FOUR:  centre_lim_q[3] <= cfg_data;
				pszbe_pkg::REG_CORNER_ONE:   corner_lim_q[0] <= cfg_data;
				pszbe_pkg::REG_CORNER_TWO:   corner_lim_q[1] <= cfg_data;
				pszbe_pkg::REG_CORNER_THREE: corner_lim_q[2] <= cfg_data;
				pszbe_pkg::REG_CORNER_FOUR:  corner_lim_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	logic valid_s1;
	logic valid_s2;
	logic s2_free;

	assign s2_free  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (s2_free)  valid_s2 <= valid_s1;
		end
	end

	// ---------------------------------------------------------------- stage 1
	pszbe_pkg::dist_t lc_s1, rc_s1, lm_s1, rm_s1;
	logic rev_s1, snd_s1, rad_s1;

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			lc_s1  <= left_corner_dist;
			rc_s1  <= right_corner_dist;
			lm_s1  <= left_centre_dist;
			rm_s1  <= right_centre_dist;
			rev_s1 <= reverse_engaged;
			snd_s1 <= sound_allowed;
			rad_s1 <= radar_valid;
		end
	end

	// ---------------------------------------------------------------- decode
	pszbe_pkg::dist_t  mn, mn_a, mn_b, centre_min, left_min, right_min;
	logic              corner;
	logic              a_right, b_right, b_wins;
	pszbe_pkg::zone_t  zl, zr, zone_c;
	pszbe_pkg::chan_t  chan;
	pszbe_pkg::delay_t delay;
	pszbe_pkg::dist_t  diff0, diff1, diff2;

	always_comb begin
		// earlier index wins ties in the nearest-distance search (mn)
		a_right = rc_s1 < lc_s1;
		mn_a    = a_right ? rc_s1 : lc_s1;
		b_right = rm_s1 < lm_s1;
		mn_b    = b_right ? rm_s1 : lm_s1;
		b_wins  = mn_b < mn_a;
		mn      = b_wins ? mn_b : mn_a;
		corner  = !b_wins;

		centre_min = mn_b;
		left_min   = (lc_s1 < lm_s1) ? lc_s1 : lm_s1;
		right_min  = (rc_s1 < rm_s1) ? rc_s1 : rm_s1;
		chan = pszbe_pkg::CHAN_BOTH;
		if (left_min < centre_min)  chan = pszbe_pkg::CHAN_LEFT;
		if (right_min < centre_min) chan = pszbe_pkg::CHAN_RIGHT;

		zl     = centre_zone_of(lm_s1, centre_lim_q);
		zr     = centre_zone_of(rm_s1, centre_lim_q);
		zone_c = (zr < zl) ? zr : zl;

		diff0 = centre_lim_q[0] - mn;
		diff1 = centre_lim_q[1] - mn;
		diff2 = centre_lim_q[2] - mn;

		delay = pszbe_pkg::DELAY_SLOWEST;
		if (corner) begin
			if (mn < corner_lim_q[0])  delay = pszbe_pkg::DELAY_SLOWEST;
			if (mn <= corner_lim_q[1]) delay = pszbe_pkg::DELAY_TWO_BAR;
			if (mn <= corner_lim_q[2]) delay = pszbe_pkg::DELAY_THREE_BAR;
			if (mn <= corner_lim_q[3]) delay = pszbe_pkg::DELAY_CONT;
		end else begin
			if (mn <= centre_lim_q[0]) begin
				delay = ({1'b0, diff0[7:1]} >= {2'b00, pszbe_pkg::DELAY_SLOWEST})
					? pszbe_pkg::DELAY_CONT
					: pszbe_pkg::DELAY_SLOWEST - diff0[6:1];
			end
			if (mn <= centre_lim_q[1]) delay = fifth_step(pszbe_pkg::DELAY_TWO_BAR, diff1);
			if (mn <= centre_lim_q[2]) delay = fifth_step(pszbe_pkg::DELAY_THREE_BAR, diff2);
			if (mn <= centre_lim_q[3]) delay = pszbe_pkg::DELAY_CONT;
		end
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			nearest_dist      <= mn;
			nearest_is_corner <= corner;
			centre_zone       <= zone_c;
			left_zone         <= corner_zone_of(lc_s1, corner_lim_q);
			right_zone        <= corner_zone_of(rc_s1, corner_lim_q);
			beep_channel      <= chan;
			beep_pause        <= delay;
			rear_active       <= rev_s1;
			sound_on          <= snd_s1 && rev_s1 && rad_s1 && (mn != pszbe_pkg::NOTHING_SEEN);
			show_display      <= rev_s1 && rad_s1;
		end
	end

	assign out_valid = valid_s2;

endmodule

// File: rtl/core/pszbe_checker.sv
// ----------------------------------------------------------------------------
// pszbe_checker
// Port-level checks for the parking sensor zone and beep encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pszbe_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              out_valid,
	input  logic              out_ready,
	input  pszbe_pkg::dist_t  nearest_dist,
	input  pszbe_pkg::zone_t  centre_zone,
	input  pszbe_pkg::delay_t beep_pause,
	input  logic              rear_active,
	input  logic              sound_on,
	input  logic              show_display
);

	// stalled beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(nearest_dist) && $stable(beep_pause) && $stable(sound_on))

	`ASSERT_SAME(a_delay_range, clk, arst_n, out_valid, beep_pause <= pszbe_pkg::DELAY_SLOWEST)

	`ASSERT_SAME(a_sound_needs_show, clk, arst_n, out_valid && sound_on, show_display && rear_active && (nearest_dist != pszbe_pkg::NOTHING_SEEN))

	`ASSERT_SAME(a_centre_zone_code, clk, arst_n, out_valid, centre_zone == pszbe_pkg::ZONE_1 || centre_zone == pszbe_pkg::ZONE_3 || centre_zone == pszbe_pkg::ZONE_5 || centre_zone == pszbe_pkg::ZONE_7 || centre_zone == pszbe_pkg::ZONE_FAR)

endmodule

bind parking_sensor_zone_beep_encoder pszbe_checker u_pszbe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.nearest_dist (nearest_dist),
	.centre_zone  (centre_zone),
	.beep_pause   (beep_pause),
	.rear_active  (rear_active),
	.sound_on     (sound_on),
	.show_display (show_display)
);
